// ===== src/lexer_with_number_conversion_core_assert.svh =====
// Assertion macros shared by the lexer core modules.
// Each macro places one labelled concurrent assertion, reset-disabled.
`ifndef LEXER_WITH_NUMBER_CONVERSION_CORE_ASSERT_SVH
`define LEXER_WITH_NUMBER_CONVERSION_CORE_ASSERT_SVH

// Condition that must hold at every edge outside reset
`define LWNC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent in the same cycle as the antecedent
`define LWNC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent
`define LWNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lwnc_pkg.sv =====
// Shared types, character constants and digit helpers for the lexer core.
// No dependencies; the lexer, queue, core and bench import this package.
`default_nettype none

package lwnc_pkg;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_LOW_B = 8'h62;
   localparam logic [7:0] CH_LOW_H = 8'h68;

   localparam logic [2:0] CLS_NUMBER = 3'd0;
   localparam logic [2:0] CLS_WORD   = 3'd1;
   localparam logic [2:0] CLS_PUNCT  = 3'd2;
   localparam logic [2:0] CLS_SPACE  = 3'd3;
   localparam logic [2:0] CLS_SHORT  = 3'd4;
   localparam logic [2:0] CLS_LONG   = 3'd5;
   localparam logic [2:0] CLS_OTHER  = 3'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  token_class;
      logic [15:0] token_length;
      logic [31:0] number_value;
      logic        number_error;
      logic        text_done;
      logic        run_last;
   } rsp_item_type;

   // Results of one accepted item, at most two
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   typedef struct packed {
      logic        fault;
      logic [31:0] acc;
   } feed_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hexdig_type;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= 8'h30) && (ch <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] ch);
      return ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A))
             || (ch == 8'h5F);
   endfunction

   // : { } . - + * = [ ]
   function automatic logic is_punct(input logic [7:0] ch);
      logic hit;
      case (ch) inside
         8'h3A, 8'h7B, 8'h7D, 8'h2E, 8'h2D, 8'h2B, 8'h2A, 8'h3D, 8'h5B, 8'h5D: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_space(input logic [7:0] ch);
      return (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
   endfunction

   function automatic hexdig_type hex_val(input logic [7:0] ch);
      hexdig_type d;
      d.ok  = 1'b1;
      d.val = 4'd0;
      if (is_digit(ch)) begin
         d.val = 4'(ch - 8'h30);
      end else if ((ch >= 8'h61) && (ch <= 8'h66)) begin
         d.val = 4'(ch - 8'h57);
      end else if ((ch >= 8'h41) && (ch <= 8'h46)) begin
         d.val = 4'(ch - 8'h37);
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

   function automatic feed_type feed_bin(input logic [31:0] acc, input logic fault,
                                         input logic [7:0] ch);
      feed_type   r;
      hexdig_type d;
      d       = hex_val(ch);
      r.acc   = acc;
      r.fault = fault;
      if (!fault) begin
         if (!d.ok || (d.val > 4'd1) || acc[31]) begin
            r.fault = 1'b1;
         end else begin
            r.acc = {acc[30:0], d.val[0]};
         end
      end
      return r;
   endfunction

   function automatic feed_type feed_hex(input logic [31:0] acc, input logic fault,
                                         input logic [7:0] ch);
      feed_type   r;
      hexdig_type d;
      d       = hex_val(ch);
      r.acc   = acc;
      r.fault = fault;
      if (!fault) begin
         if (!d.ok || (acc[31:28] != 4'd0)) begin
            r.fault = 1'b1;
         end else begin
            r.acc = {acc[27:0], d.val};
         end
      end
      return r;
   endfunction

   // acc * 10 as (acc << 3) + (acc << 1), checked against 32 bits
   function automatic feed_type feed_dec(input logic [31:0] acc, input logic fault,
                                         input logic [7:0] ch);
      feed_type    r;
      hexdig_type  d;
      logic [35:0] v;
      d       = hex_val(ch);
      v       = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + 36'(d.val);
      r.acc   = acc;
      r.fault = fault;
      if (!fault) begin
         if (!d.ok || (d.val > 4'd9) || (v[35:32] != 4'd0)) begin
            r.fault = 1'b1;
         end else begin
            r.acc = v[31:0];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/lwnc_channels.sv =====
// Valid/ready channel interfaces for the lexer core: text bytes in, tokens out.
// Depends on nothing.
`default_nettype none

interface lwnc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_text;

   modport source (output valid, output ch, output end_of_text, input ready);
   modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface lwnc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_class;
   logic [15:0] token_length;
   logic [31:0] number_value;
   logic        number_error;
   logic        text_done;
   logic        run_last;

   modport source (output valid, output token_class, output token_length,
                   output number_value, output number_error, output text_done,
                   output run_last, input ready);
   modport sink   (input valid, input token_class, input token_length,
                   input number_value, input number_error, input text_done,
                   input run_last, output ready);
endinterface

`default_nettype wire

// ===== src/lexer_with_number_conversion_core.sv =====
// C-style tokenizer with number conversion, one text byte per item.
// req_chan carries ch and end_of_text; rsp_chan carries one token per item:
// class, length, number value, number error, text_done and run_last.
// A token is reported when the byte that ends it arrives, so one byte can
// give zero, one or two tokens; run_last marks the last token of a byte and
// text_done the last token of the text.
// The tokens of a byte enter the result queue when the byte is taken and reach
// rsp_chan from its registers. Throughput: one byte per cycle while the tokens
// drain as fast as they come; the second token of a byte waits behind the first.
// Decoding and the three radix sums sit between the token state registers
// and a four-entry result queue, which also decouples the two channels.
// req_chan.ready is high while the queue has at least two free entries, so bytes
// keep being taken while a finished token waits; a stalled receiver fills the
// queue and then holds req_chan.ready low.
// Reset empties the queue and returns the lexer to no open token.
// LENGTH_BITS sets where token_length saturates (2^LENGTH_BITS-1); the port
// shows its low 16 bits.
`default_nettype none

module lexer_with_number_conversion_core
   import lwnc_pkg::*;
#(
   parameter int LENGTH_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   lwnc_req_if.sink   req_chan,
   lwnc_rsp_if.source rsp_chan
);

   push_type push;
   logic     room;

   lwnc_lexer #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_lexer (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .room  (room),
      .push  (push)
   );

   lwnc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== src/lwnc_lexer.sv =====
// Token state machine and number conversion: one byte per accepted item.
// Uses lwnc_pkg, lwnc_req_if and the assertion macros header.
`default_nettype none
`include "lexer_with_number_conversion_core_assert.svh"

module lwnc_lexer
   import lwnc_pkg::*;
#(
   parameter int LENGTH_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   lwnc_req_if.sink req,
   input  logic     room,
   output push_type push
);

   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_NUM   = 3'd1;
   localparam logic [2:0] MODE_WORD  = 3'd2;
   localparam logic [2:0] MODE_SPACE = 3'd3;
   localparam logic [2:0] MODE_SHORT = 3'd4;
   localparam logic [2:0] MODE_LONG  = 3'd5;

   localparam logic [LENGTH_BITS-1:0] RUN_MAX = '1;

   logic [2:0]             mode_ff, mode_in;
   logic                   slash_ff, slash_in;
   logic                   star_ff, star_in;
   logic [LENGTH_BITS-1:0] run_ff, run_in;
   logic [31:0]            bin_ff, bin_in;
   logic [31:0]            dec_ff, dec_in;
   logic [31:0]            hex_ff, hex_in;
   logic [2:0]             faults_ff, faults_in;
   logic [7:0]             held_ff, held_in;

   logic         step;
   logic         fresh;
   logic         close_now;
   logic         alnum;
   logic [1:0]   n;
   logic [1:0]   last;
   feed_type     fb, fh, fd;
   rsp_item_type items [2];

   function automatic logic [LENGTH_BITS-1:0] grow(input logic [LENGTH_BITS-1:0] r);
      return (r == RUN_MAX) ? r : r + LENGTH_BITS'(1);
   endfunction

   function automatic rsp_item_type plain_item(input logic [2:0] cls);
      rsp_item_type it;
      it              = '0;
      it.token_class  = cls;
      it.token_length = 16'd1;
      return it;
   endfunction

   function automatic rsp_item_type close_item(input logic [2:0] mode,
                                               input logic [LENGTH_BITS-1:0] run,
                                               input logic [7:0] held,
                                               input logic [2:0] faults,
                                               input logic [31:0] b_acc,
                                               input logic [31:0] d_acc,
                                               input logic [31:0] h_acc);
      rsp_item_type           it;
      logic [LENGTH_BITS+15:0] wide;
      wide            = {16'd0, run};
      it              = '0;
      it.token_length = wide[15:0];
      unique case (mode)
         MODE_NUM: begin
            it.token_class = CLS_NUMBER;
            if (held == CH_LOW_B) begin
               it.number_error = faults[0];
               it.number_value = b_acc;
            end else if (held == CH_LOW_H) begin
               it.number_error = faults[2];
               it.number_value = h_acc;
            end else begin
               it.number_error = faults[1];
               it.number_value = d_acc;
            end
            if (it.number_error) begin
               it.number_value = 32'd0;
            end
         end
         MODE_WORD:  it.token_class = CLS_WORD;
         MODE_SPACE: it.token_class = CLS_SPACE;
         MODE_SHORT: it.token_class = CLS_SHORT;
         MODE_LONG:  it.token_class = CLS_LONG;
         default:    it.token_class = CLS_OTHER;
      endcase
      return it;
   endfunction

   // take nothing while reset is held
   assign req.ready = room && !reset;
   assign step      = req.valid && req.ready;

   always_comb begin
      mode_in   = mode_ff;
      slash_in  = slash_ff;
      star_in   = star_ff;
      run_in    = run_ff;
      bin_in    = bin_ff;
      dec_in    = dec_ff;
      hex_in    = hex_ff;
      faults_in = faults_ff;
      held_in   = held_ff;
      fresh     = 1'b1;
      close_now = 1'b0;
      n         = 2'd0;
      last      = 2'd0;
      fb        = '0;
      fh        = '0;
      fd        = '0;
      items[0]  = '0;
      items[1]  = '0;
      alnum     = is_letter(req.ch) || is_digit(req.ch);

      if (slash_in) begin
         slash_in = 1'b0;
         if (req.ch == CH_SLASH) begin
            mode_in = MODE_SHORT;
            run_in  = LENGTH_BITS'(2);
            fresh   = 1'b0;
         end else if (req.ch == CH_STAR) begin
            mode_in = MODE_LONG;
            run_in  = LENGTH_BITS'(2);
            star_in = 1'b0;
            fresh   = 1'b0;
         end else begin
            items[n[0]] = plain_item(CLS_OTHER);
            n           = n + 2'd1;
         end
      end else begin
         unique case (mode_in)
            MODE_NUM, MODE_WORD: begin
               if (alnum) begin
                  run_in = grow(run_in);
                  if (mode_in == MODE_NUM) begin
                     // binary and hex sums lag one character behind
                     fb           = feed_bin(bin_in, faults_in[0], held_in);
                     fh           = feed_hex(hex_in, faults_in[2], held_in);
                     fd           = feed_dec(dec_in, faults_in[1], req.ch);
                     bin_in       = fb.acc;
                     hex_in       = fh.acc;
                     dec_in       = fd.acc;
                     faults_in    = {fh.fault, fd.fault, fb.fault};
                     held_in      = req.ch;
                  end
                  fresh = 1'b0;
               end else begin
                  close_now = 1'b1;
               end
            end
            MODE_SPACE: begin
               if (is_space(req.ch)) begin
                  run_in = grow(run_in);
                  fresh  = 1'b0;
               end else begin
                  close_now = 1'b1;
               end
            end
            MODE_SHORT: begin
               if (req.ch != CH_LF) begin
                  run_in = grow(run_in);
                  fresh  = 1'b0;
               end else begin
                  close_now = 1'b1;
               end
            end
            MODE_LONG: begin
               run_in = grow(run_in);
               fresh  = 1'b0;
               if (star_in && (req.ch == CH_SLASH)) begin
                  close_now = 1'b1;
               end else begin
                  star_in = (req.ch == CH_STAR);
               end
            end
            default: ;
         endcase
      end

      if (close_now) begin
         items[n[0]] = close_item(mode_in, run_in, held_in, faults_in, bin_in, dec_in, hex_in);
         n           = n + 2'd1;
         mode_in     = MODE_IDLE;
         star_in     = 1'b0;
         run_in      = '0;
         bin_in      = 32'd0;
         dec_in      = 32'd0;
         hex_in      = 32'd0;
         faults_in   = 3'd0;
         held_in     = 8'd0;
      end

      if (fresh) begin
         if (is_digit(req.ch)) begin
            mode_in      = MODE_NUM;
            run_in       = LENGTH_BITS'(1);
            fd           = feed_dec(dec_in, faults_in[1], req.ch);
            dec_in       = fd.acc;
            faults_in[1] = fd.fault;
            held_in      = req.ch;
         end else if (is_letter(req.ch)) begin
            mode_in = MODE_WORD;
            run_in  = LENGTH_BITS'(1);
         end else if (is_punct(req.ch)) begin
            items[n[0]] = plain_item(CLS_PUNCT);
            n           = n + 2'd1;
         end else if (is_space(req.ch)) begin
            mode_in = MODE_SPACE;
            run_in  = LENGTH_BITS'(1);
         end else if (req.ch == CH_SLASH) begin
            slash_in = 1'b1;
         end else begin
            items[n[0]] = plain_item(CLS_OTHER);
            n           = n + 2'd1;
         end
      end

      // flush everything open on the final byte
      if (req.end_of_text) begin
         if (mode_in != MODE_IDLE) begin
            items[n[0]] = close_item(mode_in, run_in, held_in, faults_in, bin_in, dec_in,
                                     hex_in);
            n           = n + 2'd1;
         end
         if (slash_in) begin
            items[n[0]] = plain_item(CLS_OTHER);
            n           = n + 2'd1;
         end
         mode_in   = MODE_IDLE;
         slash_in  = 1'b0;
         star_in   = 1'b0;
         run_in    = '0;
         bin_in    = 32'd0;
         dec_in    = 32'd0;
         hex_in    = 32'd0;
         faults_in = 3'd0;
         held_in   = 8'd0;
      end

      if (n != 2'd0) begin
         last                    = n - 2'd1;
         items[last[0]].run_last  = 1'b1;
         items[last[0]].text_done = req.end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         slash_ff  <= 1'b0;
         star_ff   <= 1'b0;
         run_ff    <= '0;
         bin_ff    <= 32'd0;
         dec_ff    <= 32'd0;
         hex_ff    <= 32'd0;
         faults_ff <= 3'd0;
         held_ff   <= 8'd0;
      end else if (step) begin
         mode_ff   <= mode_in;
         slash_ff  <= slash_in;
         star_ff   <= star_in;
         run_ff    <= run_in;
         bin_ff    <= bin_in;
         dec_ff    <= dec_in;
         hex_ff    <= hex_in;
         faults_ff <= faults_in;
         held_ff   <= held_in;
      end
   end

   assign push.count  = step ? n : 2'd0;
   assign push.first  = items[0];
   assign push.second = items[1];

   `LWNC_ASSERT_SAME(a_slash_only_idle, clock, reset, slash_ff, mode_ff == MODE_IDLE, "pending slash with open token")
   `LWNC_ASSERT_NEXT(a_eot_clears, clock, reset, step && req.end_of_text, (mode_ff == MODE_IDLE) && !slash_ff && (run_ff == '0), "state not cleared after final byte")
   `LWNC_ASSERT_SAME(a_pair_last, clock, reset, push.count == 2'd2, push.second.run_last && !push.first.run_last, "run_last not on second result")

endmodule

`default_nettype wire

// ===== src/lwnc_queue.sv =====
// Result queue of four token entries; takes up to two per cycle, gives one.
// Uses lwnc_pkg, lwnc_rsp_if and the assertion macros header.
`default_nettype none
`include "lexer_with_number_conversion_core_assert.svh"

module lwnc_queue
   import lwnc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   lwnc_rsp_if.source rsp
);

   rsp_item_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ff;
   logic [PTR_BITS-1:0]   rd_ff;
   logic [PTR_BITS-1:0]   wr_next;
   logic [CNT_BITS-1:0]   count_ff;
   logic                  pop;
   rsp_item_type          head;

   assign pop     = rsp.valid && rsp.ready;
   assign wr_next = wr_ff + PTR_BITS'(1);
   // room for the worst case of two results per item
   assign room    = count_ff <= CNT_BITS'(QUEUE_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + PTR_BITS'(push.count);
         rd_ff    <= rd_ff + PTR_BITS'(pop);
         count_ff <= count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

   assign head             = entries_ff[rd_ff];
   assign rsp.valid        = count_ff != '0;
   assign rsp.token_class  = head.token_class;
   assign rsp.token_length = head.token_length;
   assign rsp.number_value = head.number_value;
   assign rsp.number_error = head.number_error;
   assign rsp.text_done    = head.text_done;
   assign rsp.run_last     = head.run_last;

   `LWNC_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_BITS'(QUEUE_DEPTH), "queue count above depth")
   `LWNC_ASSERT_SAME(a_push_fits, clock, reset, push.count != 2'd0, room, "push into full queue")
   `LWNC_ASSERT_NEXT(a_pop_only, clock, reset, pop && (push.count == 2'd0), count_ff == $past(count_ff) - CNT_BITS'(1), "count not reduced by lone pop")

endmodule

`default_nettype wire

// ===== test/lexer_with_number_conversion_core_tb.sv =====
// Self-checking bench for lexer_with_number_conversion_core: feeds text bytes,
// predicts every token in a scoreboard class and checks each result item.
// Depends on lwnc_pkg, the lwnc_channels interfaces and the core.
module lexer_with_number_conversion_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lwnc_pkg::*;

   localparam int    SAT_LENGTH     = 65535;
   localparam int    WATCHDOG_LIMIT = 4000;
   localparam int    PHASE_ITEMS    = 350;
   localparam string WORD_CHARS     =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   localparam string PUNCT_CHARS    = ":{}.-+*=[]";

   typedef enum logic [2:0] {
      LEX_IDLE, LEX_NUM, LEX_WORD, LEX_SPACE, LEX_SHORT, LEX_LONG
   } lex_mode_type;

   class token_board;
      lex_mode_type mode;
      bit           slash_open;
      bit           star_prev;
      int unsigned  run_len;
      logic [31:0]  sum_bin;
      logic [31:0]  sum_dec;
      logic [31:0]  sum_hex;
      logic [2:0]   faults;     // bit 0 binary, bit 1 decimal, bit 2 hex
      logic [7:0]   last_digit;
      rsp_item_type step_tokens[$];
      rsp_item_type awaited[$];
      int           mismatches;
      int           tokens_seen;

      function new();
         mismatches  = 0;
         tokens_seen = 0;
         slash_open  = 1'b0;
         clear_token();
      endfunction

      function void clear_token();
         mode       = LEX_IDLE;
         star_prev  = 1'b0;
         run_len    = 0;
         sum_bin    = '0;
         sum_dec    = '0;
         sum_hex    = '0;
         faults     = '0;
         last_digit = '0;
      endfunction

      function bit digit_ch(logic [7:0] c);
         return (c >= 8'h30) && (c <= 8'h39);
      endfunction

      function bit letter_ch(logic [7:0] c);
         return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                || (c == 8'h5F);
      endfunction

      function bit punct_ch(logic [7:0] c);
         for (int i = 0; i < PUNCT_CHARS.len(); i++)
            if (PUNCT_CHARS[i] == c) return 1'b1;
         return 1'b0;
      endfunction

      function bit space_ch(logic [7:0] c);
         return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
      endfunction

      function int digit_weight(logic [7:0] c);
         if (digit_ch(c)) return int'(c) - 8'h30;
         if ((c >= 8'h61) && (c <= 8'h66)) return int'(c) - 8'h61 + 10;
         if ((c >= 8'h41) && (c <= 8'h46)) return int'(c) - 8'h41 + 10;
         return -1;
      endfunction

      // Fold one character into a radix sum; faults are sticky
      function logic [31:0] add_digit(logic [31:0] acc, int base, int bit_no,
                                      logic [7:0] c);
         int              d;
         longint unsigned v;
         d = digit_weight(c);
         if (faults[bit_no]) return acc;
         if ((d < 0) || (d >= base)) begin
            faults[bit_no] = 1'b1;
            return acc;
         end
         v = 64'(acc) * 64'(base) + 64'(d);
         if (v > 64'hFFFF_FFFF) begin
            faults[bit_no] = 1'b1;
            return acc;
         end
         return v[31:0];
      endfunction

      function void lengthen();
         if (run_len < SAT_LENGTH) run_len++;
      endfunction

      function void emit(logic [2:0] cls, int unsigned len, logic [31:0] val, logic err);
         rsp_item_type t;
         t.token_class  = cls;
         t.token_length = 16'(len);
         t.number_value = val;
         t.number_error = err;
         t.text_done    = 1'b0;
         t.run_last     = 1'b0;
         step_tokens.push_back(t);
      endfunction

      function void close_open();
         logic [2:0]  cls;
         logic [31:0] val;
         logic        err;
         val = '0;
         err = 1'b0;
         case (mode)
            LEX_NUM: begin
               cls = CLS_NUMBER;
               if (last_digit == CH_LOW_B) begin
                  err = faults[0];
                  val = sum_bin;
               end else if (last_digit == CH_LOW_H) begin
                  err = faults[2];
                  val = sum_hex;
               end else begin
                  err = faults[1];
                  val = sum_dec;
               end
               if (err) val = '0;
            end
            LEX_WORD:  cls = CLS_WORD;
            LEX_SPACE: cls = CLS_SPACE;
            LEX_SHORT: cls = CLS_SHORT;
            LEX_LONG:  cls = CLS_LONG;
            default: begin
               clear_token();
               return;
            end
         endcase
         emit(cls, run_len, val, err);
         clear_token();
      endfunction

      function void open_token(logic [7:0] c);
         if (digit_ch(c)) begin
            mode       = LEX_NUM;
            run_len    = 1;
            sum_dec    = add_digit(sum_dec, 10, 1, c);
            last_digit = c;
         end else if (letter_ch(c)) begin
            mode    = LEX_WORD;
            run_len = 1;
         end else if (punct_ch(c)) begin
            emit(CLS_PUNCT, 1, '0, 1'b0);
         end else if (space_ch(c)) begin
            mode    = LEX_SPACE;
            run_len = 1;
         end else if (c == CH_SLASH) begin
            slash_open = 1'b1;
         end else begin
            emit(CLS_OTHER, 1, '0, 1'b0);
         end
      endfunction

      // Advance the lexer by one accepted byte and queue the tokens it closes
      function void note_byte(logic [7:0] c, logic eot);
         bit starts;
         int tail;
         starts = 1'b1;
         step_tokens.delete();
         if (slash_open) begin
            slash_open = 1'b0;
            if (c == CH_SLASH) begin
               mode    = LEX_SHORT;
               run_len = 2;
               starts  = 1'b0;
            end else if (c == CH_STAR) begin
               mode      = LEX_LONG;
               run_len   = 2;
               star_prev = 1'b0;
               starts    = 1'b0;
            end else begin
               emit(CLS_OTHER, 1, '0, 1'b0);
            end
         end else begin
            case (mode)
               LEX_NUM, LEX_WORD: begin
                  if (letter_ch(c) || digit_ch(c)) begin
                     lengthen();
                     // binary and hex sums trail by one character: the last may be a suffix
                     if (mode == LEX_NUM) begin
                        sum_bin    = add_digit(sum_bin, 2, 0, last_digit);
                        sum_hex    = add_digit(sum_hex, 16, 2, last_digit);
                        sum_dec    = add_digit(sum_dec, 10, 1, c);
                        last_digit = c;
                     end
                     starts = 1'b0;
                  end else begin
                     close_open();
                  end
               end
               LEX_SPACE: begin
                  if (space_ch(c)) begin
                     lengthen();
                     starts = 1'b0;
                  end else begin
                     close_open();
                  end
               end
               LEX_SHORT: begin
                  if (c != CH_LF) begin
                     lengthen();
                     starts = 1'b0;
                  end else begin
                     close_open();
                  end
               end
               LEX_LONG: begin
                  lengthen();
                  starts = 1'b0;
                  if (star_prev && (c == CH_SLASH)) close_open();
                  else star_prev = (c == CH_STAR);
               end
               default: ;
            endcase
         end
         if (starts) open_token(c);
         if (eot) begin
            if (mode != LEX_IDLE) close_open();
            if (slash_open) emit(CLS_OTHER, 1, '0, 1'b0);
            clear_token();
            slash_open = 1'b0;
            if (step_tokens.size() > 0) begin
               tail = step_tokens.size() - 1;
               step_tokens[tail].text_done = 1'b1;
            end
         end
         if (step_tokens.size() > 0) begin
            tail = step_tokens.size() - 1;
            step_tokens[tail].run_last = 1'b1;
         end
         foreach (step_tokens[i]) awaited.push_back(step_tokens[i]);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < 100) $display("MISMATCH token %0d: %s", tokens_seen, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
      endtask

      task check_token(rsp_item_type got);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("unexpected token class %0d length %0d",
                                      got.token_class, got.token_length));
            tokens_seen++;
            return;
         end
         want = awaited.pop_front();
         compare_field("token_class", 32'(got.token_class), 32'(want.token_class));
         compare_field("token_length", 32'(got.token_length), 32'(want.token_length));
         compare_field("number_value", got.number_value, want.number_value);
         compare_field("number_error", 32'(got.number_error), 32'(want.number_error));
         compare_field("text_done", 32'(got.text_done), 32'(want.text_done));
         compare_field("run_last", 32'(got.run_last), 32'(want.run_last));
         tokens_seen++;
      endtask
   endclass

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       src_valid    = 1'b0;
   logic [7:0] src_ch       = 8'h00;
   logic       src_eot      = 1'b0;
   logic       sink_ready   = 1'b0;
   int         src_idle_pct   = 0;
   int         sink_stall_pct = 0;
   int         quiet_cycles   = 0;
   int         random_sent;
   logic [7:0] text_q[$];
   token_board board;

   lwnc_req_if req_if ();
   lwnc_rsp_if rsp_if ();

   assign req_if.valid       = src_valid;
   assign req_if.ch          = src_ch;
   assign req_if.end_of_text = src_eot;
   assign rsp_if.ready       = sink_ready;

   lexer_with_number_conversion_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver: stall at random, check every accepted item
   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_if.valid && sink_ready) begin
         got.token_class  = rsp_if.token_class;
         got.token_length = rsp_if.token_length;
         got.number_value = rsp_if.number_value;
         got.number_error = rsp_if.number_error;
         got.text_done    = rsp_if.text_done;
         got.run_last     = rsp_if.run_last;
         board.check_token(got);
      end
      sink_ready <= reset ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (src_valid && req_if.ready) || (rsp_if.valid && sink_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("lexer_with_number_conversion_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(logic [7:0] c, logic eot);
      while ($urandom_range(99) < src_idle_pct) begin
         src_valid <= 1'b0;
         @(posedge clock);
      end
      src_valid <= 1'b1;
      src_ch    <= c;
      src_eot   <= eot;
      do @(posedge clock); while (!req_if.ready);
      board.note_byte(c, eot);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // Append a string, optionally with one character replaced and hex letters raised
   function automatic void push_chars(string s, int bad_pos, logic [7:0] bad_ch, bit upper);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (upper && (c >= 8'h61) && (c <= 8'h66)) c = c - 8'h20;
         if (i == bad_pos) c = bad_ch;
         text_q.push_back(c);
      end
   endfunction

   function automatic void add_fragment();
      longint unsigned v;
      string           s;
      int              pick;
      int              bad_pos;
      int              count;
      pick    = int'($urandom_range(99));
      bad_pos = -1;
      if (pick < 16) begin
         case ($urandom_range(3))
            0:       v = 64'($urandom_range(999));
            1:       v = 64'($urandom);
            2:       v = 64'd4294967290 + 64'($urandom_range(12));
            default: v = {$urandom, $urandom};
         endcase
         s = $sformatf("%0d", v);
         if ($urandom_range(9) == 0) bad_pos = int'($urandom_range(s.len() - 1));
         push_chars(s, bad_pos, 8'h41 + 8'($urandom_range(25)), 1'b0);
      end else if (pick < 28) begin
         v = {$urandom, $urandom} >> $urandom_range(63, 30);
         s = $sformatf("%0b", v);
         if ($urandom_range(7) == 0) bad_pos = int'($urandom_range(s.len() - 1));
         push_chars(s, bad_pos, 8'h32 + 8'($urandom_range(7)), 1'b0);
         text_q.push_back(CH_LOW_B);
      end else if (pick < 40) begin
         v = {$urandom, $urandom} >> $urandom_range(63, 26);
         s = $sformatf("%0h", v);
         // leading zero keeps a letter from opening a word
         if ((s[0] > 8'h39) || ($urandom_range(3) == 0)) text_q.push_back(8'h30);
         if ($urandom_range(7) == 0) bad_pos = int'($urandom_range(s.len() - 1));
         push_chars(s, bad_pos, 8'h67 + 8'($urandom_range(19)), 1'($urandom_range(1)));
         text_q.push_back(CH_LOW_H);
      end else if (pick < 52) begin
         text_q.push_back(WORD_CHARS[$urandom_range(52)]);
         repeat ($urandom_range(7)) text_q.push_back(WORD_CHARS[$urandom_range(62)]);
      end else if (pick < 62) begin
         text_q.push_back(PUNCT_CHARS[$urandom_range(PUNCT_CHARS.len() - 1)]);
      end else if (pick < 70) begin
         repeat ($urandom_range(4, 1))
            text_q.push_back($urandom_range(5) == 0 ? 8'h20 : 8'h09 + 8'($urandom_range(4)));
      end else if (pick < 77) begin
         push_chars("//", -1, 8'h00, 1'b0);
         repeat ($urandom_range(8)) text_q.push_back(8'h20 + 8'($urandom_range(94)));
         if ($urandom_range(1)) text_q.push_back(CH_LF);
      end else if (pick < 85) begin
         push_chars("/*", -1, 8'h00, 1'b0);
         count = int'($urandom_range(10));
         repeat (count) begin
            case ($urandom_range(3))
               0:       text_q.push_back(CH_STAR);
               1:       text_q.push_back(CH_SLASH);
               default: text_q.push_back(8'($urandom_range(255)));
            endcase
         end
         if ($urandom_range(9) < 7) push_chars("*/", -1, 8'h00, 1'b0);
      end else if (pick < 91) begin
         text_q.push_back(CH_SLASH);
      end else begin
         text_q.push_back(8'($urandom_range(255)));
      end
   endfunction

   task automatic send_random_text();
      text_q.delete();
      repeat ($urandom_range(12, 1)) begin
         add_fragment();
         if ($urandom_range(4) < 2) text_q.push_back(8'h20);
      end
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      random_sent += text_q.size();
   endtask

   task automatic run_directed();
      send_text("0Fh+101b/x");
      send_text("12/-a/");
      send_text("//c*/\n/*/*/ ");
      send_text("4294967295:4294967296");
      send_text("1g2h=2b/*x");
      send_text("{}.[]");
      send_byte(8'h00, 1'b0);
      send_byte(8'h0B, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h0D, 1'b0);
      send_byte(8'h80, 1'b1);
      send_text("/");
      send_text("/*");
      // long comment closed by the final byte
      send_byte(CH_SLASH, 1'b0);
      send_byte(CH_STAR, 1'b0);
      repeat (40) send_byte(8'h61, 1'b0);
      send_byte(CH_STAR, 1'b0);
      send_byte(CH_SLASH, 1'b1);
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               src_idle_pct   = 0;
               sink_stall_pct = 0;
            end
            1: begin
               src_idle_pct   = 77;
               sink_stall_pct = 0;
            end
            2: begin
               src_idle_pct   = 0;
               sink_stall_pct = 77;
            end
            default: begin
               src_idle_pct   = 12;
               sink_stall_pct = 12;
            end
         endcase
         random_sent = 0;
         while (random_sent < PHASE_ITEMS) send_random_text();
      end
      src_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("lexer_with_number_conversion_core verification clean");
      end else begin
         $display("lexer_with_number_conversion_core verification failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+src
src/lwnc_pkg.sv
src/lwnc_channels.sv
src/lwnc_lexer.sv
src/lwnc_queue.sv
src/lexer_with_number_conversion_core.sv
test/lexer_with_number_conversion_core_tb.sv
